FILE: hw/rtl/mmsn_pkg.sv
// Package for the min/max sample normaliser.
// Holds default widths, the result class codes and the front-to-back control struct.
// No dependencies.
package mmsn_pkg;

  // Default configuration
  localparam int SampleBitsDef = 32;
  localparam int OutputBitsDef = 16;
  localparam int FifoDepthDef  = 4;

  // How the back end forms the scaled value
  typedef enum logic [1:0] {
    RES_ZERO = 2'd0,  // missing, degenerate range or at/below minimum
    RES_FULL = 2'd1,  // at/above maximum
    RES_DIV  = 2'd2   // strictly inside the range, needs the divider
  } res_code_e;

  // Control part of a queued convert word
  typedef struct packed {
    res_code_e code;
    logic      miss;
    logic      last;
  } item_ctl_t;

endpackage

FILE: hw/rtl/mmsn_stream_if.sv
// Stream interfaces for the min/max sample normaliser: input words and result words.
// Depends on nothing; widths come from the interface parameters.
interface mmsn_in_if #(
  parameter int SAMPLE_BITS = 32
);
  logic                          valid;
  logic                          ready;
  logic                          action;
  logic signed [SAMPLE_BITS-1:0] sample;
  logic                          last;

  modport source (output valid, output action, output sample, output last, input ready);
  modport sink   (input valid, input action, input sample, input last, output ready);
endinterface

interface mmsn_out_if #(
  parameter int OUTPUT_BITS = 16
);
  logic                   valid;
  logic                   ready;
  logic [OUTPUT_BITS-1:0] scaled;
  logic                   was_missing;
  logic                   last_out;

  modport source (output valid, output scaled, output was_missing, output last_out,
                  input ready);
  modport sink   (input valid, input scaled, input was_missing, input last_out,
                  output ready);
endinterface

FILE: hw/rtl/mmsn_fifo.sv
// Small register queue between the front and back ends of the normaliser.
// Generic width and depth; no package dependency.
module mmsn_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] rdata_o,
  output logic             empty_o
);

  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(DEPTH);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PtrW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]  cnt_q;

  assign full_o  = (cnt_q == FullCnt);
  assign empty_o = (cnt_q == '0);
  assign rdata_o = mem_q[rd_ptr_q];

  // Storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

FILE: hw/rtl/mmsn_front.sv
// Front end of the normaliser: takes input words, tracks min/max, classifies convert words.
// Depends on mmsn_pkg and mmsn_in_if.
module mmsn_front #(
  parameter int SAMPLE_BITS = mmsn_pkg::SampleBitsDef
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [SAMPLE_BITS-1:0] cfg_wdata_i,
  mmsn_in_if.sink                in_i,
  output logic                   push_o,
  output mmsn_pkg::item_ctl_t    ctl_o,
  output logic [SAMPLE_BITS-1:0] diff_o,
  output logic [SAMPLE_BITS-1:0] range_o,
  input  logic                   full_i
);

  localparam logic [SAMPLE_BITS-1:0] MissReset = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

  logic signed [SAMPLE_BITS-1:0] missing_q;
  logic signed [SAMPLE_BITS-1:0] lo_q, hi_q;
  logic                          any_q;

  logic signed [SAMPLE_BITS-1:0] s;
  logic                          accept, miss, degen;
  logic [SAMPLE_BITS:0]          diff_w, range_w;

  assign s         = in_i.sample;
  assign in_i.ready = !full_i;
  assign accept    = in_i.valid && !full_i;
  assign miss      = (s == missing_q);
  assign degen     = !any_q || (hi_q <= lo_q);
  assign push_o    = accept && in_i.action;

  // Offset and span against the tracked minimum (sign-extended by one bit)
  assign diff_w  = {s[SAMPLE_BITS-1], s} - {lo_q[SAMPLE_BITS-1], lo_q};
  assign range_w = {hi_q[SAMPLE_BITS-1], hi_q} - {lo_q[SAMPLE_BITS-1], lo_q};
  assign diff_o  = diff_w[SAMPLE_BITS-1:0];
  assign range_o = range_w[SAMPLE_BITS-1:0];

  // Classify a convert word
  always_comb begin
    ctl_o.miss = miss;
    ctl_o.last = in_i.last;
    if (miss || degen || (s <= lo_q)) begin
      ctl_o.code = mmsn_pkg::RES_ZERO;
    end else if (s >= hi_q) begin
      ctl_o.code = mmsn_pkg::RES_FULL;
    end else begin
      ctl_o.code = mmsn_pkg::RES_DIV;
    end
  end

  // Missing-value register and min/max tracker
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      missing_q <= MissReset;
      lo_q      <= '0;
      hi_q      <= '0;
      any_q     <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        missing_q <= cfg_wdata_i;
      end
      if (accept && !in_i.action && !miss) begin
        if (!any_q) begin
          lo_q  <= s;
          hi_q  <= s;
          any_q <= 1'b1;
        end else begin
          if (s < lo_q) lo_q <= s;
          if (s > hi_q) hi_q <= s;
        end
      end else if (accept && in_i.action && in_i.last) begin
        // last convert word closes the frame
        lo_q  <= '0;
        hi_q  <= '0;
        any_q <= 1'b0;
      end
    end
  end

endmodule

FILE: hw/rtl/mmsn_back.sv
// Back end of the normaliser: forms scaled results, bit-serial divider, output register.
// Depends on mmsn_pkg and mmsn_out_if.
module mmsn_back #(
  parameter int SAMPLE_BITS = mmsn_pkg::SampleBitsDef,
  parameter int OUTPUT_BITS = mmsn_pkg::OutputBitsDef
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   empty_i,
  input  mmsn_pkg::item_ctl_t    ctl_i,
  input  logic [SAMPLE_BITS-1:0] diff_i,
  input  logic [SAMPLE_BITS-1:0] range_i,
  output logic                   pop_o,
  mmsn_out_if.source             out_o
);

  localparam int CntW = $clog2(OUTPUT_BITS + 1);
  localparam int NumW = SAMPLE_BITS + OUTPUT_BITS;
  localparam logic [CntW-1:0] Steps = CntW'(OUTPUT_BITS);
  localparam logic [OUTPUT_BITS-1:0] OutMax = '1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_HOLD
  } state_e;

  state_e                 state_q;
  logic [SAMPLE_BITS-1:0] rem_q, range_q;
  logic [OUTPUT_BITS-1:0] nq_q;      // numerator low bits in, quotient bits out
  logic [CntW-1:0]        cnt_q;
  logic                   last_q;
  logic                   ovalid_q, omiss_q, olast_q;
  logic [OUTPUT_BITS-1:0] oscaled_q;

  logic                   out_free;
  logic                   load_out;
  logic [NumW-1:0]        num;
  logic [SAMPLE_BITS:0]   trial, sub;
  logic                   ge;
  logic [SAMPLE_BITS-1:0] rem_d;

  assign out_free = !ovalid_q || out_o.ready;
  assign pop_o    = (state_q == ST_IDLE) && !empty_i &&
                    ((ctl_i.code == mmsn_pkg::RES_DIV) || out_free);

  // Output register takes a new word this cycle
  assign load_out = (pop_o && (ctl_i.code != mmsn_pkg::RES_DIV)) ||
                    ((state_q == ST_HOLD) && out_free);

  // diff * (2^OUTPUT_BITS - 1) as shift and subtract
  assign num = {diff_i, {OUTPUT_BITS{1'b0}}} - {{OUTPUT_BITS{1'b0}}, diff_i};

  // One restoring-division step
  assign trial = {rem_q, nq_q[OUTPUT_BITS-1]};
  assign sub   = trial - {1'b0, range_q};
  assign ge    = (trial >= {1'b0, range_q});
  assign rem_d = ge ? sub[SAMPLE_BITS-1:0] : trial[SAMPLE_BITS-1:0];

  assign out_o.valid       = ovalid_q;
  assign out_o.scaled      = oscaled_q;
  assign out_o.was_missing = omiss_q;
  assign out_o.last_out    = olast_q;

  // Sequencer, divider datapath and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      rem_q     <= '0;
      range_q   <= '0;
      nq_q      <= '0;
      cnt_q     <= '0;
      last_q    <= 1'b0;
      ovalid_q  <= 1'b0;
      omiss_q   <= 1'b0;
      olast_q   <= 1'b0;
      oscaled_q <= '0;
    end else begin
      if (load_out) begin
        ovalid_q <= 1'b1;
      end else if (out_o.valid && out_o.ready) begin
        ovalid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (pop_o) begin
            if (ctl_i.code == mmsn_pkg::RES_DIV) begin
              rem_q   <= num[NumW-1:OUTPUT_BITS];
              nq_q    <= num[OUTPUT_BITS-1:0];
              range_q <= range_i;
              cnt_q   <= Steps;
              last_q  <= ctl_i.last;
              state_q <= ST_DIV;
            end else begin
              oscaled_q <= (ctl_i.code == mmsn_pkg::RES_FULL) ? OutMax : '0;
              omiss_q   <= ctl_i.miss;
              olast_q   <= ctl_i.last;
            end
          end
        end
        ST_DIV: begin
          rem_q <= rem_d;
          nq_q  <= {nq_q[OUTPUT_BITS-2:0], ge};
          cnt_q <= cnt_q - 1'b1;
          if (cnt_q == CntW'(1)) begin
            state_q <= ST_HOLD;
          end
        end
        ST_HOLD: begin
          if (out_free) begin
            oscaled_q <= nq_q;
            omiss_q   <= 1'b0;
            olast_q   <= last_q;
            state_q   <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

FILE: hw/rtl/min_max_sample_normaliser.sv
// Min/max sample normaliser. Measure words are absorbed one per cycle by the front end
// while the queue has room.
// A convert word that ends at zero or full scale passes through the queue to the output register;
// one inside the range also passes through the one-bit-per-cycle divider, which finishes each
// division before it takes the next. A FIFO_DEPTH-deep queue (4 by default) decouples the ends.
// Reset clears the tracker and sets the missing value to the most negative sample code.
// Depends on mmsn_pkg, mmsn_stream_if, mmsn_fifo, mmsn_front and mmsn_back.
module min_max_sample_normaliser #(
  parameter int SAMPLE_BITS = mmsn_pkg::SampleBitsDef,
  parameter int OUTPUT_BITS = mmsn_pkg::OutputBitsDef,
  parameter int FIFO_DEPTH  = mmsn_pkg::FifoDepthDef
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [SAMPLE_BITS-1:0] cfg_wdata_i,
  mmsn_in_if.sink                in_i,
  mmsn_out_if.source             out_o
);

  localparam int CtlW  = $bits(mmsn_pkg::item_ctl_t);
  localparam int WordW = CtlW + 2 * SAMPLE_BITS;

  logic                   push, pop, full, empty;
  mmsn_pkg::item_ctl_t    f_ctl, b_ctl;
  logic [SAMPLE_BITS-1:0] f_diff, f_range, b_diff, b_range;
  logic [WordW-1:0]       wdata, rdata;

  mmsn_front #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_i        (in_i),
    .push_o      (push),
    .ctl_o       (f_ctl),
    .diff_o      (f_diff),
    .range_o     (f_range),
    .full_i      (full)
  );

  assign wdata = {f_ctl, f_diff, f_range};
  assign {b_ctl, b_diff, b_range} = rdata;

  mmsn_fifo #(
    .WIDTH (WordW),
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (wdata),
    .full_o  (full),
    .pop_i   (pop),
    .rdata_o (rdata),
    .empty_o (empty)
  );

  mmsn_back #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .OUTPUT_BITS (OUTPUT_BITS)
  ) u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .empty_i (empty),
    .ctl_i   (b_ctl),
    .diff_i  (b_diff),
    .range_i (b_range),
    .pop_o   (pop),
    .out_o   (out_o)
  );

  // Queue is never written when full nor read when empty
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> !full) else $error("queue written while full");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> !empty) else $error("queue read while empty");

  // A missing sample always scales to zero
  a_missing_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.was_missing) |-> (out_o.scaled == '0))
    else $error("missing sample gave nonzero result");

endmodule
